// ===== design/shbi_pkg.sv =====
// ----------------------------------------------------------------------------
// shbi_pkg
// Shared types and constants for the string hash bucket index block.
// ----------------------------------------------------------------------------
package shbi_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned AccW = 64;
	localparam int unsigned SizeW = 32;
	localparam int unsigned DivCntW = $clog2(AccW);

	localparam logic [ByteW-1:0] KeyEndByte = 8'd0;
	localparam logic [SizeW-1:0] TableSizeReset = 32'd5;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic acc_step;
		logic div_start;
		logic div_step;
		logic res_load;
	} ctl_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic key_end;
	} dp_sts_t;

endpackage

// ===== design/shbi_key_if.sv =====
// ----------------------------------------------------------------------------
// shbi_key_if
// Key byte channel: one key character per beat.
// ----------------------------------------------------------------------------
interface shbi_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

// ===== design/shbi_idx_if.sv =====
// ----------------------------------------------------------------------------
// shbi_idx_if
// Bucket index channel: one result per completed key.
// ----------------------------------------------------------------------------
interface shbi_idx_if;
	logic        valid;
	logic        ready;
	logic [31:0] bucket_index;

	modport source (output valid, output bucket_index, input ready);
	modport sink (input valid, input bucket_index, output ready);
endinterface

// ===== design/shbi_cfg_if.sv =====
// ----------------------------------------------------------------------------
// shbi_cfg_if
// Configuration write channel for the table size register.
// ----------------------------------------------------------------------------
interface shbi_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] table_size;

	modport source (output valid, output table_size, input ready);
	modport sink (input valid, input table_size, output ready);
endinterface

// ===== design/shbi_datapath.sv =====
// ----------------------------------------------------------------------------
// shbi_datapath
// Hash accumulator, table size register, restoring divider and result register.
// ----------------------------------------------------------------------------
module shbi_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  shbi_pkg::ctl_cmd_t      cmd,
	output shbi_pkg::dp_sts_t       sts,
	input  logic [7:0]              key_byte,
	input  logic                    cfg_wr,
	input  logic [31:0]             cfg_size,
	output logic [31:0]             bucket_index
);
	import shbi_pkg::*;

	logic [AccW-1:0]  acc_q;
	logic [AccW-1:0]  acc_next;
	logic [SizeW-1:0] tsize_q;
	logic [SizeW-1:0] div_q;
	logic             zero_q;
	logic [AccW-1:0]  dvd_q;
	logic [SizeW-1:0] rem_q;
	logic [SizeW-1:0] res_q;
	logic [SizeW:0]   trial;
	logic [SizeW+1:0] diff;

	assign sts.key_end = (key_byte == KeyEndByte);

	// acc * 101 + byte, as shifts and adds (101 = 64 + 32 + 4 + 1)
	assign acc_next = (acc_q << 6) + (acc_q << 5) + (acc_q << 2) + acc_q
		+ {{(AccW-ByteW){1'b0}}, key_byte};

	// accumulator: cleared when a key ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.div_start) begin
			acc_q <= '0;
		end else if (cmd.acc_step) begin
			acc_q <= acc_next;
		end
	end

	// table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TableSizeReset;
		end else if (cfg_wr) begin
			tsize_q <= cfg_size;
		end
	end

	// one quotient bit per step: shift in dividend MSB, subtract if it fits
	assign trial = {rem_q, dvd_q[AccW-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q  <= acc_q;
			rem_q  <= '0;
			div_q  <= tsize_q;
			zero_q <= (tsize_q == '0);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[AccW-2:0], 1'b0};
			if (!diff[SizeW+1]) begin
				rem_q <= diff[SizeW-1:0];
			end else begin
				rem_q <= trial[SizeW-1:0];
			end
		end
	end

	// result register; zero table size gives index 0
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= zero_q ? '0 : rem_q;
		end
	end

	assign bucket_index = res_q;

endmodule

// ===== design/shbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// shbi_ctrl
// Sequencer: accepts key bytes, runs the divider, owns the result valid flag.
// ----------------------------------------------------------------------------
module shbi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 key_valid,
	output logic                 key_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  shbi_pkg::dp_sts_t    sts,
	output shbi_pkg::ctl_cmd_t   cmd
);
	import shbi_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [DivCntW-1:0] cnt_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		key_ready     = 1'b0;
		cmd.acc_step  = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.res_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				key_ready = 1'b1;
				if (key_valid) begin
					if (sts.key_end) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						cmd.acc_step = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/string_hash_bucket_index.sv =====
// ----------------------------------------------------------------------------
// string_hash_bucket_index
// Polynomial string hash (acc * 101 + byte) reduced modulo the table size.
// ----------------------------------------------------------------------------
// Nonzero key bytes: one beat per cycle, no result.
// Terminating zero byte: runs the 64-step restoring divider, one bit per cycle,
// then loads the result into the index register; input stalls meanwhile.
// Reset: accumulator 0, table size 5, no result pending; config always ready.
module string_hash_bucket_index (
	input  logic        clk,
	input  logic        arst_n,
	shbi_key_if.sink    key,
	shbi_idx_if.source  result,
	shbi_cfg_if.sink    cfg
);
	import shbi_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	assign cfg.ready = 1'b1;

	shbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key.valid),
		.key_ready (key.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	shbi_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.key_byte     (key.key_byte),
		.cfg_wr       (cfg.valid && cfg.ready),
		.cfg_size     (cfg.table_size),
		.bucket_index (result.bucket_index)
	);

	// a terminating byte always stalls the key input next cycle
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(key.valid && key.ready && key.key_byte == KeyEndByte) |=> !key.ready)
		else $error("key input not stalled after end byte");

	// input only stalls because a key ended
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(key.ready) |-> $past(key.valid && key.key_byte == KeyEndByte))
		else $error("key input stalled without end byte");

	// a new result appears only at the end of a stall
	a_result_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!key.ready))
		else $error("result raised outside divide sequence");

endmodule

// ===== tb/bucket_index_checker.sv =====
// ----------------------------------------------------------------------------
// bucket_index_checker
// Watches the key, index and table size channels. It keeps its own copy of
// the hash accumulator and table size, predicts one bucket index per
// terminated key, and compares each index beat with the oldest prediction.
// ----------------------------------------------------------------------------
module bucket_index_checker (
	input  logic        clk,
	input  logic        arst_n,
	shbi_key_if         key,
	shbi_idx_if         result,
	shbi_cfg_if         cfg,
	input  logic        run_end,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import shbi_pkg::*;

	localparam logic [AccW-1:0] HashMult = 64'd101;

	logic [AccW-1:0]  hash_acc;
	logic [SizeW-1:0] buckets;
	logic [SizeW-1:0] expected_idx[$];
	logic [SizeW-1:0] want;
	int unsigned      mismatches;
	int unsigned      idx_beats;
	bit               end_checked;

	// acc * 101 + byte, wrapping at 64 bits
	function automatic logic [AccW-1:0] fold_byte(input logic [AccW-1:0] acc,
			input logic [ByteW-1:0] b);
		return acc * HashMult + {{(AccW-ByteW){1'b0}}, b};
	endfunction

	// final reduction; a zero table size yields bucket 0
	function automatic logic [SizeW-1:0] reduce_to_bucket(input logic [AccW-1:0] acc,
			input logic [SizeW-1:0] size);
		logic [AccW-1:0] rem;
		if (size == '0)
			return '0;
		rem = acc % {{(AccW-SizeW){1'b0}}, size};
		return rem[SizeW-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] index check: %s", $realtime, msg);
		mismatches++;
	endtask

	// predict on key beats, compare on index beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_acc = '0;
			buckets = TableSizeReset;
			expected_idx.delete();
			mismatches = 0;
			idx_beats = 0;
			end_checked = 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				buckets = cfg.table_size;

			if (key.valid && key.ready) begin
				if (key.key_byte == KeyEndByte) begin
					expected_idx.push_back(reduce_to_bucket(hash_acc, buckets));
					hash_acc = '0;
				end else begin
					hash_acc = fold_byte(hash_acc, key.key_byte);
				end
			end

			if (result.valid && result.ready) begin
				idx_beats++;
				if (expected_idx.size() == 0) begin
					report_mismatch($sformatf("unexpected index beat, bucket_index %0d",
						result.bucket_index));
				end else begin
					want = expected_idx.pop_front();
					if (result.bucket_index !== want)
						report_mismatch($sformatf("bucket_index got %0d want %0d",
							result.bucket_index, want));
				end
			end

			// keys still waiting for an index at the end of the run
			if (run_end && !end_checked) begin
				end_checked = 1'b1;
				if (expected_idx.size() != 0)
					report_mismatch($sformatf("%0d keys never produced an index",
						expected_idx.size()));
			end
		end
		fail_count <= mismatches;
		pending <= expected_idx.size();
		results_seen <= idx_beats;
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives key bytes and table size writes into string_hash_bucket_index with
// bursty input and a stalling index receiver; a checker beside the block
// predicts and compares every bucket index.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import shbi_pkg::*;

	localparam int RandomBytes  = 1350;
	localparam int SettleCycles = 80;
	localparam int IdleLimit    = 3000;
	localparam int HoldCycles   = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic run_end;

	shbi_key_if key_ch();
	shbi_idx_if idx_ch();
	shbi_cfg_if cfg_ch();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_seen;

	int unsigned bytes_sent;
	int unsigned keys_sent;
	int unsigned sizes_written;
	int          burst_left;
	bit          drain_hold;
	logic [9:0]  stall_phase;

	string_hash_bucket_index i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.key   (key_ch),
		.result(idx_ch),
		.cfg   (cfg_ch)
	);

	bucket_index_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key_ch),
		.result      (idx_ch),
		.cfg         (cfg_ch),
		.run_end     (run_end),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen)
	);

	always #1 clk = ~clk;

	// one key byte beat; the sender idles between bursts
	task automatic send_byte(input logic [ByteW-1:0] b);
		if (burst_left <= 0) begin
			key_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
		end
		key_ch.valid <= 1'b1;
		key_ch.key_byte <= b;
		do @(posedge clk); while (!key_ch.ready);
		burst_left--;
		bytes_sent++;
	endtask

	// random key body without its terminator
	task automatic send_key_body(input int len, input bit full_range);
		for (int i = 0; i < len; i++)
			send_byte(full_range ? ByteW'($urandom_range(1, 255))
				: ByteW'($urandom_range(97, 122)));
	endtask

	task automatic end_key();
		send_byte(KeyEndByte);
		keys_sent++;
	endtask

	// let every index drain, then give the block time to go quiet
	task automatic settle();
		key_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_table_size(input logic [SizeW-1:0] size);
		cfg_ch.valid <= 1'b1;
		cfg_ch.table_size <= size;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sizes_written++;
	endtask

	// index receiver: its own stall pattern, plus one long hold-off on request
	initial begin
		idx_ch.ready <= 1'b0;
		stall_phase = '0;
		forever begin
			@(posedge clk);
			if (drain_hold) begin
				idx_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				drain_hold = 1'b0;
			end else begin
				stall_phase++;
				case (stall_phase[9:7])
					3'd0, 3'd1: idx_ch.ready <= 1'b1;
					3'd2, 3'd3: idx_ch.ready <= 1'($urandom_range(0, 1));
					3'd4, 3'd5: idx_ch.ready <= ($urandom_range(0, 3) != 0);
					3'd6: idx_ch.ready <= (stall_phase[2:0] == 3'd0);
					default: idx_ch.ready <= stall_phase[3];
				endcase
			end
		end
	end

	// watchdog: ends the run after too many cycles without any beat
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IdleLimit) begin
			@(posedge clk);
			if ((key_ch.valid && key_ch.ready) || (idx_ch.valid && idx_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no beat for %0d cycles, %0d indexes pending", IdleLimit, pending);
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		logic [SizeW-1:0] size;
		int               phase;
		int               len;

		key_ch.valid <= 1'b0;
		key_ch.key_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.table_size <= '0;
		run_end <= 1'b0;
		drain_hold = 1'b0;
		burst_left = 0;
		bytes_sent = 0;
		keys_sent = 0;
		sizes_written = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset table size, empty key and a one-byte key
		end_key();
		send_byte(8'hFF);
		end_key();

		// largest table size with an accumulator that wraps past 64 bits
		settle();
		write_table_size(32'hFFFF_FFFF);
		repeat (11) send_byte(8'hFF);
		end_key();

		// single bucket
		settle();
		write_table_size(32'd1);
		send_byte(8'h55);
		send_byte(8'hAA);
		end_key();

		// size changed to zero in the middle of a key
		send_byte(8'h80);
		send_byte(8'h01);
		settle();
		write_table_size('0);
		end_key();

		// random phases, each with its own table size
		phase = 0;
		while (bytes_sent < RandomBytes + 21) begin
			settle();
			case ($urandom_range(0, 9))
				0: size = 32'd1;
				1: size = 32'hFFFF_FFFF;
				2, 3: size = SizeW'($urandom_range(2, 16));
				4: size = SizeW'($urandom_range(17, 65535));
				5: size = SizeW'($urandom_range(1000, 100000));
				6: size = (phase % 4 == 3) ? '0 : SizeW'($urandom);
				default: size = SizeW'($urandom);
			endcase
			write_table_size(size);
			if (phase == 2)
				drain_hold = 1'b1;

			repeat ($urandom_range(6, 14)) begin
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(12, 40);
				else
					len = $urandom_range(0, 12);
				send_key_body(len, $urandom_range(0, 2) != 0);
				end_key();
			end

			// sometimes leave a key open across the size change
			if ($urandom_range(0, 2) == 0)
				send_key_body($urandom_range(1, 6), 1'b1);
			phase++;
		end

		// close any open key and drain
		end_key();
		settle();
		run_end <= 1'b1;
		repeat (2) @(posedge clk);

		$display("run covered %0d key bytes in %0d keys over %0d table size settings",
			bytes_sent, keys_sent, sizes_written + 1);
		$display("%0d bucket indexes compared, %0d mismatches", results_seen, fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
